// ===== rtl/core/spk_pkg.sv =====
package spk_pkg;

  localparam int unsigned Rounds = 32;
  localparam int unsigned RkW = $clog2(Rounds);
  localparam int unsigned WordW = 64;
  localparam int unsigned IdxW = 3;

  typedef logic [WordW-1:0] word_t;
  typedef logic [RkW-1:0] rk_idx_t;
  typedef logic [IdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgKeyLow = 3'd0;
  localparam cfg_idx_t CfgKeyHigh = 3'd1;
  localparam cfg_idx_t CfgIvLow = 3'd2;
  localparam cfg_idx_t CfgIvHigh = 3'd3;
  localparam cfg_idx_t CfgMode = 3'd4;

  // control from sequencer to bit-serial datapath
  typedef struct packed {
    logic load;
    logic step;
    logic first;
    logic decrypt;
  } dp_ctrl_t;

endpackage

// ===== rtl/core/spk_serial_add.sv =====
// bit-serial add or subtract over shift words, one bit per cycle while en is high, lsb first
module spk_serial_add (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic en,
  input  logic sub,
  input  logic a,
  input  logic b,
  output logic s
);
  logic carry;
  logic carry_in;
  logic bb;

  assign carry_in = start ? sub : carry;
  assign bb = b ^ sub;
  assign s = a ^ bb ^ carry_in;

  // carry flop
  always_ff @(posedge clk) begin
    if (rst) begin
      carry <= 1'b0;
    end else if (en) begin
      carry <= (a & bb) | (a & carry_in) | (bb & carry_in);
    end
  end
endmodule

// ===== rtl/core/spk_round_unit.sv =====
// one speck round (forward or inverse) done bit-serially
module spk_round_unit (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic decrypt,
  input  spk_pkg::word_t x_in,
  input  spk_pkg::word_t y_in,
  input  spk_pkg::word_t k_in,
  output spk_pkg::word_t x_out,
  output spk_pkg::word_t y_out,
  output logic done
);
  import spk_pkg::*;

  logic [6:0] cnt;
  logic busy;
  word_t a_sh, b_sh, k_sh, x_in_r, y_in_r, ybase, res_sh;
  logic s_bit;

  // serial add/sub: fwd (x ror 8) + y, inv (x ^ k) - (y ^ x) ror 3
  spk_serial_add u_add (
    .clk(clk), .rst(rst), .start(cnt == 7'd0), .en(busy), .sub(decrypt),
    .a(a_sh[0]), .b(b_sh[0]), .s(s_bit)
  );

  always_comb begin
    ybase = ((y_in ^ x_in) >> 3) | ((y_in ^ x_in) << 61);
  end

  // busy flag, bit counter and done strobe, one bit per cycle while busy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'(WordW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_in_r <= x_in;
      y_in_r <= y_in;
      k_sh <= k_in;
      if (decrypt) begin
        a_sh <= x_in ^ k_in;
        b_sh <= ybase;
      end else begin
        a_sh <= (x_in >> 8) | (x_in << 56);
        b_sh <= y_in;
      end
    end else if (busy) begin
      a_sh <= a_sh >> 1;
      b_sh <= b_sh >> 1;
      k_sh <= k_sh >> 1;
      res_sh <= {(decrypt ? s_bit : (s_bit ^ k_sh[0])), res_sh[WordW-1:1]};
    end
  end

  // final rotates and xors are wiring plus one xor level
  always_comb begin
    if (decrypt) begin
      x_out = (res_sh << 8) | (res_sh >> 56);
      y_out = ((y_in_r ^ x_in_r) >> 3) | ((y_in_r ^ x_in_r) << 61);
    end else begin
      x_out = res_sh;
      y_out = ((y_in_r << 3) | (y_in_r >> 61)) ^ res_sh;
    end
  end
endmodule

// ===== rtl/core/speck128_cbc_cipher.sv =====
// channel  direction  handshake        payload
// in       input      valid/stall      block_low, block_high, last_block
// out      output     valid/stall      out_low, out_high, out_last
// cfg      input      valid/ready      addr, data
// a round steps through key read, start, the serial bits, done.
// a block takes 32 rounds plus accept and output;
// the first block of a message adds key expansion of 31 forward rounds.
// rst is synchronous, active high, clears control and config registers.
// a stalled result holds in the output register; the next item waits for it.
module speck128_cbc_cipher (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  input  logic last_block,
  output logic out_valid,
  input  logic out_stall,
  output logic [63:0] out_low,
  output logic [63:0] out_high,
  output logic out_last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_addr,
  input  logic [63:0] cfg_data
);
  import spk_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_KEY, S_KWAIT, S_RND, S_RLOAD, S_RWAIT, S_OUT
  } state_t;

  state_t state;
  word_t key_low, key_high, iv_low, iv_high;
  logic mode;
  word_t rk_mem [Rounds];
  word_t rk_rd;
  word_t chain_low, chain_high, x, y, lo_r, hi_r, kk, ll;
  logic last_r, dec_r, in_message;
  rk_idx_t ridx;
  logic ru_start, ru_dec, ru_done;
  word_t ru_x, ru_y, ru_k, ru_xo, ru_yo;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0; key_high <= '0; iv_low <= '0; iv_high <= '0; mode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        CfgKeyLow: key_low <= cfg_data;
        CfgKeyHigh: key_high <= cfg_data;
        CfgIvLow: iv_low <= cfg_data;
        CfgIvHigh: iv_high <= cfg_data;
        CfgMode: mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // round key memory
  always_ff @(posedge clk) begin
    if (state == S_KWAIT && ru_done) rk_mem[ridx + rk_idx_t'(1)] <= ru_yo;
    else if (state == S_KEY && ridx == '0) rk_mem[0] <= kk;
    rk_rd <= rk_mem[ridx];
  end

  // key schedule reuses the forward round with x = l, y = k, key = round count
  always_comb begin
    ru_start = 1'b0;
    ru_dec = 1'b0;
    ru_x = x; ru_y = y; ru_k = rk_rd;
    if (state == S_KEY || state == S_KWAIT) begin
      ru_x = ll; ru_y = kk; ru_k = word_t'(ridx);
    end else begin
      ru_dec = dec_r;
    end
    ru_start = (state == S_KEY && ridx != rk_idx_t'(Rounds - 1)) || state == S_RLOAD;
  end

  spk_round_unit u_round (
    .clk(clk), .rst(rst), .start(ru_start), .decrypt(ru_dec),
    .x_in(ru_x), .y_in(ru_y), .k_in(ru_k),
    .x_out(ru_xo), .y_out(ru_yo), .done(ru_done)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      in_message <= 1'b0;
      out_valid <= 1'b0;
      chain_low <= '0;
      chain_high <= '0;
      ridx <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          lo_r <= block_low; hi_r <= block_high; last_r <= last_block; dec_r <= mode;
          ridx <= (in_message && mode) ? rk_idx_t'(Rounds - 1) : '0;
          if (!in_message) begin
            kk <= key_low; ll <= key_high;
            chain_low <= iv_low; chain_high <= iv_high;
            state <= S_KEY;
          end else begin
            state <= S_RND;
          end
          if (mode) begin
            x <= block_low; y <= block_high;
          end else begin
            x <= block_low ^ (in_message ? chain_low : iv_low);
            y <= block_high ^ (in_message ? chain_high : iv_high);
          end
          in_message <= !last_block;
        end
        S_KEY: if (ridx == rk_idx_t'(Rounds - 1)) begin
          ridx <= dec_r ? rk_idx_t'(Rounds - 1) : '0;
          state <= S_RND;
        end else begin
          state <= S_KWAIT;
        end
        S_KWAIT: if (ru_done) begin
          ll <= ru_xo; kk <= ru_yo;
          ridx <= ridx + rk_idx_t'(1);
          state <= S_KEY;
        end
        // round key read cycle
        S_RND: state <= S_RLOAD;
        S_RLOAD: state <= S_RWAIT;
        S_RWAIT: if (ru_done) begin
          x <= ru_xo; y <= ru_yo;
          if ((dec_r && ridx == '0) || (!dec_r && ridx == rk_idx_t'(Rounds - 1))) begin
            state <= S_OUT;
            out_valid <= 1'b1;
            if (dec_r) begin
              out_low <= ru_xo ^ chain_low; out_high <= ru_yo ^ chain_high;
              chain_low <= lo_r; chain_high <= hi_r;
            end else begin
              out_low <= ru_xo; out_high <= ru_yo;
              chain_low <= ru_xo; chain_high <= ru_yo;
            end
            out_last <= last_r;
          end else begin
            ridx <= dec_r ? ridx - rk_idx_t'(1) : ridx + rk_idx_t'(1);
            state <= S_RND;
          end
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_low))
    else $error("result lost under stall");
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    ru_done |-> (state == S_KWAIT || state == S_RWAIT))
    else $error("round unit finished outside wait");
`endif
endmodule

// ===== bench/speck128_cbc_checker.sv =====
module speck128_cbc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  input  logic        last_block,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_low,
  input  logic [63:0] out_high,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import spk_pkg::*;

  typedef struct {
    word_t lo;
    word_t hi;
    logic  last;
  } cipher_block_t;

  // shadow of the config registers and the chaining state
  word_t key_lo, key_hi, iv_lo, iv_hi;
  logic  decrypt;
  word_t sched_keys [Rounds];
  word_t chain_lo, chain_hi;
  logic  msg_open;
  cipher_block_t expected_blocks [$];

  function automatic word_t ror64(word_t v, int r);
    return (v >> r) | (v << (WordW - r));
  endfunction

  function automatic word_t rol64(word_t v, int r);
    return (v << r) | (v >> (WordW - r));
  endfunction

  // key schedule into the round key array
  task automatic expand_key();
    word_t k, l;
    k = key_lo;
    l = key_hi;
    sched_keys[0] = k;
    for (int i = 0; i < Rounds - 1; i++) begin
      l = (ror64(l, 8) + k) ^ word_t'(i);
      k = rol64(k, 3) ^ l;
      sched_keys[i+1] = k;
    end
  endtask

  // cbc step for one accepted block
  task automatic cbc_block(input word_t lo, input word_t hi, input logic last);
    word_t x, y;
    cipher_block_t res;
    if (!msg_open) begin
      expand_key();
      chain_lo = iv_lo;
      chain_hi = iv_hi;
      msg_open = 1'b1;
    end
    if (!decrypt) begin
      x = lo ^ chain_lo;
      y = hi ^ chain_hi;
      for (int i = 0; i < Rounds; i++) begin
        x = (ror64(x, 8) + y) ^ sched_keys[i];
        y = rol64(y, 3) ^ x;
      end
      chain_lo = x;
      chain_hi = y;
    end else begin
      x = lo;
      y = hi;
      for (int i = Rounds - 1; i >= 0; i--) begin
        y = ror64(y ^ x, 3);
        x = rol64((x ^ sched_keys[i]) - y, 8);
      end
      x = x ^ chain_lo;
      y = y ^ chain_hi;
      chain_lo = lo;
      chain_hi = hi;
    end
    res.lo = x;
    res.hi = y;
    res.last = last;
    expected_blocks.push_back(res);
    if (last) msg_open = 1'b0;
  endtask

  // watch cfg, result and input transfers
  always @(posedge clk) begin
    cipher_block_t exp_blk;
    if (rst) begin
      key_lo = '0;
      key_hi = '0;
      iv_lo = '0;
      iv_hi = '0;
      decrypt = 1'b0;
      chain_lo = '0;
      chain_hi = '0;
      msg_open = 1'b0;
      expected_blocks.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_addr))
          CfgKeyLow:  key_lo = cfg_data;
          CfgKeyHigh: key_hi = cfg_data;
          CfgIvLow:   iv_lo = cfg_data;
          CfgIvHigh:  iv_hi = cfg_data;
          CfgMode:    decrypt = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          $error("unexpected result transfer out_low=%h out_high=%h", out_low, out_high);
          fail_count <= fail_count + 1;
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (out_low !== exp_blk.lo || out_high !== exp_blk.hi ||
              out_last !== exp_blk.last) begin
            if (out_low !== exp_blk.lo)
              $error("out_low expected %h actual %h", exp_blk.lo, out_low);
            if (out_high !== exp_blk.hi)
              $error("out_high expected %h actual %h", exp_blk.hi, out_high);
            if (out_last !== exp_blk.last)
              $error("out_last expected %b actual %b", exp_blk.last, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) cbc_block(block_low, block_high, last_block);
    end
    pending <= expected_blocks.size();
  end
endmodule

// ===== bench/tb_speck128_cbc_cipher.sv =====
module tb_speck128_cbc_cipher;
  timeunit 1ns;
  timeprecision 1ps;
  import spk_pkg::*;

  localparam int NumItems = 1350;
  localparam longint CycleLimit = 40_000_000;

  logic        clk;
  logic        rst;
  logic        in_valid, in_stall;
  logic [63:0] block_low, block_high;
  logic        last_block;
  logic        out_valid, out_stall;
  logic [63:0] out_low, out_high;
  logic        out_last;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_addr;
  logic [63:0] cfg_data;
  int          fail_count, pending;
  longint      cycle_count = 0;
  int          items_sent;
  int          burst_left;

  speck128_cbc_cipher DUT (.*);

  speck128_cbc_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side back-pressure in phases: none, random, solid
  int stall_style, stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 2);
      stall_left <= $urandom_range(1, 40);
      out_stall <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= 1'b1;
      endcase
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one block transfer, with bursts and gaps on the sender side
  task automatic send_block(input word_t lo, input word_t hi, input logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    block_low <= lo;
    block_high <= hi;
    last_block <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // hold off until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input word_t val);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_key_iv(input word_t kl, input word_t kh, input word_t il,
                             input word_t ih);
    cfg_write(CfgKeyLow, kl);
    cfg_write(CfgKeyHigh, kh);
    cfg_write(CfgIvLow, il);
    cfg_write(CfgIvHigh, ih);
  endtask

  initial begin
    int msg_len;
    rst <= 1'b1;
    in_valid <= 1'b0;
    block_low <= '0;
    block_high <= '0;
    last_block <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_addr <= '0;
    cfg_data <= '0;
    items_sent = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config, single-block messages at the extremes
    send_block('0, '0, 1'b1);
    send_block('1, '1, 1'b1);
    drain();
    load_key_iv(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, '1, '1);
    cfg_write(CfgMode, 64'd0);
    send_block(64'h7469206564616d20, 64'h6c61766975716520, 1'b0);
    send_block('1, '0, 1'b0);
    send_block('0, '1, 1'b1);
    drain();
    // decrypt, with mode flipped mid-message
    cfg_write(CfgMode, 64'd1);
    send_block('1, '1, 1'b0);
    drain();
    cfg_write(CfgMode, 64'd0);
    send_block(64'h0123456789abcdef, '0, 1'b0);
    drain();
    cfg_write(CfgMode, 64'd1);
    // key write inside a message acts from the next message
    load_key_iv('1, '1, '0, '0);
    send_block('0, '0, 1'b1);
    send_block('0, '0, 1'b1);
    drain();
    // writes beyond the register list are dropped
    cfg_write(cfg_idx_t'(5), '1);
    cfg_write(cfg_idx_t'(6), '1);
    cfg_write(cfg_idx_t'(7), '1);
    send_block('1, '1, 1'b1);
    drain();

    // random messages with occasional reconfiguration
    while (items_sent < NumItems) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        load_key_iv(rand_word(), rand_word(), rand_word(), rand_word());
        cfg_write(CfgMode, word_t'($urandom_range(0, 1)));
        if ($urandom_range(0, 7) == 0) cfg_write(cfg_idx_t'($urandom_range(5, 7)), rand_word());
      end
      msg_len = $urandom_range(1, 8);
      for (int i = 0; i < msg_len; i++) begin
        if ($urandom_range(0, 15) == 0) begin
          drain();
          if ($urandom_range(0, 1)) cfg_write(CfgMode, word_t'($urandom_range(0, 1)));
          else cfg_write(cfg_idx_t'($urandom_range(0, 3)), rand_word());
        end
        send_block(rand_word(), rand_word(), i == msg_len - 1);
      end
    end
    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/spk_pkg.sv
rtl/core/spk_serial_add.sv
rtl/core/spk_round_unit.sv
rtl/core/speck128_cbc_cipher.sv
bench/speck128_cbc_checker.sv
bench/tb_speck128_cbc_cipher.sv
